@@ sv/scbrf_pkg.sv @@
// ----------------------------------------------------------------------------
// scbrf_pkg
// shared types and constants for the status/control bit register file
// ----------------------------------------------------------------------------
package scbrf_pkg;

  localparam int WORD_COUNT = 17;
  localparam int WORD_W     = 12;
  localparam int WIDX_W     = $clog2(WORD_COUNT);
  localparam int DES_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // fixed words touched by the refresh logic
  localparam int WRD_PP_P   = 5;
  localparam int WRD_LOCK   = 6;
  localparam int WRD_PP_SEL = 10;
  localparam int WRD_MEMQ   = 14;
  localparam int WRD_MODEL  = 15;
  localparam int WRD_CPU    = 16;

  // number of PPs on one barrel
  localparam int PP_PER_BARREL = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ON_SECOND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TWENTY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE  = 2'd3;

  typedef enum logic [2:0] {
    OP_READ       = 3'd0,
    OP_TEST       = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_TEST_CLEAR = 3'd3,
    OP_SET        = 3'd4,
    OP_TEST_SET   = 3'd5,
    OP_CLEAR_ALL  = 3'd6,
    OP_TEST_ERR   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REFRESH,
    ST_EXECUTE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic refresh;
    logic execute;
  } cmd_t;

endpackage

@@ sv/scbrf_dp.sv @@
// ----------------------------------------------------------------------------
// scbrf_dp
// status word file, request registers, refresh and bit operation datapath
// ----------------------------------------------------------------------------
module scbrf_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  scbrf_pkg::cmd_t                    cmd,
  input  logic [2:0]                         op,
  input  logic [scbrf_pkg::DES_W-1:0]        designator,
  input  logic [scbrf_pkg::WORD_W-1:0]       selected_pp_p,
  input  logic                               cpu_stopped,
  input  logic                               monitor_mode,
  input  logic                               expanded_address,
  input  logic                               cfg_write,
  input  logic [scbrf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scbrf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [scbrf_pkg::WORD_W-1:0]       reply
);
  import scbrf_pkg::*;

  logic [WORD_W-1:0]     words [WORD_COUNT];

  logic                  on_second_channel;
  logic                  twenty_pps;
  logic                  model_865;
  logic [CFG_DATA_W-1:0] memory_size_code;

  op_t                   op_q;
  logic [DES_W-1:0]      des_q;
  logic [WORD_W-1:0]     pp_p_q;
  logic                  cpu_stopped_q;
  logic                  monitor_q;
  logic                  exp_addr_q;

  logic [15:0]           quot_prod;
  logic [WIDX_W-1:0]     word_idx;
  logic [DES_W-1:0]      word_base;
  logic [DES_W-1:0]      bit_rem;
  logic [3:0]            bit_pos;
  logic                  word_ok;
  logic                  des_ok;
  logic                  is_test;
  logic                  is_refresh_op;
  logic [DES_W-1:0]      target;
  logic [WIDX_W-1:0]     rd_idx;
  logic                  rd_ok;
  logic [WORD_W-1:0]     rd_word;
  logic                  rd_bit;
  logic                  err_any;
  logic [3:0]            pp_sel;
  logic [WORD_W-1:0]     pp_word;
  logic [2:0]            mem_quarters;
  logic [3:0]            mem_therm;
  logic [WORD_W-1:0]     reply_next;

  // designator / 12 by reciprocal multiply, exact for 8-bit designators
  assign quot_prod = 16'(des_q) * 16'd171;
  assign word_idx  = quot_prod[15:11];
  assign word_base = 8'({word_idx, 3'b000}) + 8'({word_idx, 2'b00});
  assign bit_rem   = des_q - word_base;
  assign bit_pos   = bit_rem[3:0];
  assign word_ok   = word_idx < WIDX_W'(WORD_COUNT);
  assign des_ok    = des_q < DES_W'(WORD_COUNT);

  assign is_test = (op_q == OP_TEST) || (op_q == OP_TEST_CLEAR) || (op_q == OP_TEST_SET);
  assign is_refresh_op = (op_q == OP_READ) || is_test;

  assign target = (op_q == OP_READ) ? des_q : DES_W'(word_idx);

  assign rd_idx  = (op_q == OP_READ) ? des_q[WIDX_W-1:0] : word_idx;
  assign rd_ok   = (op_q == OP_READ) ? des_ok : word_ok;
  assign rd_word = rd_ok ? words[rd_idx] : '0;
  assign rd_bit  = rd_word[bit_pos];

  assign err_any = (|words[0]) || (|words[1]) || (|words[2]) || (|words[3][3:0]);

  // refresh values
  assign pp_sel  = words[WRD_PP_SEL][3:0];
  assign pp_word = ((pp_sel < 4'(PP_PER_BARREL)) && (!on_second_channel || twenty_pps))
                   ? pp_p_q : '0;
  assign mem_quarters = (memory_size_code > 3'd4) ? 3'd0 : memory_size_code;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mem_therm[i] = 3'(i) < mem_quarters;
    end
  end

  always_comb begin
    case (op_q)
      OP_READ:       reply_next = rd_word;
      OP_TEST,
      OP_TEST_CLEAR,
      OP_TEST_SET:   reply_next = {{(WORD_W-1){1'b0}}, rd_bit};
      OP_TEST_ERR:   reply_next = {{(WORD_W-1){1'b0}}, err_any};
      default:       reply_next = '0;
    endcase
  end

  // request registers and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q          <= op_t'(op);
      des_q         <= designator;
      pp_p_q        <= selected_pp_p;
      cpu_stopped_q <= cpu_stopped;
      monitor_q     <= monitor_mode;
      exp_addr_q    <= expanded_address;
    end
    if (cmd.execute) begin
      reply <= reply_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      on_second_channel <= 1'b0;
      twenty_pps        <= 1'b0;
      model_865         <= 1'b0;
      memory_size_code  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ON_SECOND: on_second_channel <= cfg_data[0];
        CFG_TWENTY:    twenty_pps        <= cfg_data[0];
        CFG_MODEL:     model_865         <= cfg_data[0];
        CFG_MEM_SIZE:  memory_size_code  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // status word file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WORD_COUNT; i++) begin
        words[i] <= '0;
      end
    end else if (cmd.refresh && is_refresh_op) begin
      case (target)
        DES_W'(WRD_PP_P): begin
          if (!words[WRD_LOCK][11]) begin
            words[WRD_PP_P] <= pp_word;
          end
        end
        DES_W'(WRD_LOCK): begin
          words[WRD_LOCK][3:0] <= 4'b0000;
        end
        DES_W'(WRD_MEMQ): begin
          if (model_865) begin
            words[WRD_MEMQ][11:8] <= mem_therm;
          end
        end
        DES_W'(WRD_MODEL): begin
          if (model_865) begin
            words[WRD_MODEL][2:0] <= 3'b001;
          end
        end
        DES_W'(WRD_CPU): begin
          words[WRD_CPU][0]  <= cpu_stopped_q;
          words[WRD_CPU][1]  <= 1'b0;
          words[WRD_CPU][3]  <= monitor_q;
          words[WRD_CPU][4]  <= 1'b0;
          words[WRD_CPU][11] <= 1'b0;
          if (model_865) begin
            words[WRD_CPU][10] <= exp_addr_q;
          end
        end
        default: ;
      endcase
    end else if (cmd.execute) begin
      case (op_q)
        OP_CLEAR,
        OP_TEST_CLEAR: begin
          if (word_ok) begin
            words[word_idx][bit_pos] <= 1'b0;
          end
        end
        OP_SET,
        OP_TEST_SET: begin
          if (word_ok) begin
            words[word_idx][bit_pos] <= 1'b1;
          end
        end
        OP_CLEAR_ALL: begin
          for (int i = 0; i < WORD_COUNT; i++) begin
            words[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ sv/scbrf_ctrl.sv @@
// ----------------------------------------------------------------------------
// scbrf_ctrl
// request sequencer: capture, refresh, execute, result valid
// ----------------------------------------------------------------------------
module scbrf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output scbrf_pkg::cmd_t cmd
);
  import scbrf_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_REFRESH;
        end
      end
      ST_REFRESH: begin
        cmd.refresh = 1'b1;
        state_next  = ST_EXECUTE;
      end
      ST_EXECUTE: begin
        // hold until the result register is empty or being drained
        if (out_free) begin
          cmd.execute    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/status_control_bit_register_file.sv @@
// ----------------------------------------------------------------------------
// status_control_bit_register_file: reply is registered after the refresh and execute states
// one request in flight, no new request until the reply is loaded (capture, refresh, execute sequencer)
// synchronous rst clears all status words, config registers and control state
// ----------------------------------------------------------------------------
module status_control_bit_register_file (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         op,
  input  logic [scbrf_pkg::DES_W-1:0]        designator,
  input  logic [scbrf_pkg::WORD_W-1:0]       selected_pp_p,
  input  logic                               cpu_stopped,
  input  logic                               monitor_mode,
  input  logic                               expanded_address,
  // reply channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [scbrf_pkg::WORD_W-1:0]       reply,
  // configuration write port
  input  logic                               cfg_write,
  input  logic [scbrf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scbrf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import scbrf_pkg::*;

  cmd_t cmd;

  // sequencer: one request in flight, the reply register decouples the
  // output side so a new request can be taken while a reply waits
  scbrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // word file in flops, refresh of the live words, bit set/clear/test
  scbrf_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .op               (op),
    .designator       (designator),
    .selected_pp_p    (selected_pp_p),
    .cpu_stopped      (cpu_stopped),
    .monitor_mode     (monitor_mode),
    .expanded_address (expanded_address),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .reply            (reply)
  );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: status/control bit register file testbench
// drives request transfers in random bursts against a request-level shadow of
// the status words, checks every reply in order, and walks the register
// settings including the extreme memory size codes and channel modes
// ----------------------------------------------------------------------------
module tb_top;
  import scbrf_pkg::*;

  localparam int CYCLE_LIMIT        = 400000;
  localparam int SETTLE_CYCLES      = 6;
  localparam int HOLDOFF_CYCLES     = 150;
  localparam int RANDOM_PER_SETTING = 210;
  localparam int FLOOD_ITEMS        = 40;
  localparam int MAX_REPORTED       = 10;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [2:0]            op;
  logic [DES_W-1:0]      designator;
  logic [WORD_W-1:0]     selected_pp_p;
  logic                  cpu_stopped;
  logic                  monitor_mode;
  logic                  expanded_address;
  logic                  out_valid;
  logic                  out_stall;
  logic [WORD_W-1:0]     reply;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // one reply still owed by the block, oldest first
  typedef struct {
    op_t              opc;
    logic [DES_W-1:0] des;
    logic [WORD_W-1:0] value;
  } pending_reply_t;

  pending_reply_t pending_replies[$];

  // shadow copy of the status words and the settings
  logic [WORD_W-1:0]     shadow_words [WORD_COUNT];
  logic                  sh_on_second;
  logic                  sh_twenty;
  logic                  sh_model;
  logic [CFG_DATA_W-1:0] sh_mem_size;

  int cycle_count      = 0;
  int failure_count    = 0;
  int replies_checked  = 0;
  int requests_sent    = 0;
  int settings_used    = 0;
  int holdoff_requests = 0;
  int holdoff_served   = 0;

  status_control_bit_register_file dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .designator       (designator),
    .selected_pp_p    (selected_pp_p),
    .cpu_stopped      (cpu_stopped),
    .monitor_mode     (monitor_mode),
    .expanded_address (expanded_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .reply            (reply),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               pending_replies.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // shadow model of the block
  // ------------------------------------------------------------------------

  function automatic logic [DES_W-1:0] flat_bit(int w, int b);
    return DES_W'(w * WORD_W + b);
  endfunction

  // words that track inputs and settings are brought up to date before a read or test
  function automatic void refresh_word(int unsigned w, logic [WORD_W-1:0] pp, logic cpu,
                                       logic mon, logic xa);
    case (w)
      WRD_PP_P: begin
        // locked pp field holds word 5 as it stands
        if (!shadow_words[WRD_LOCK][11]) begin
          if (shadow_words[WRD_PP_SEL][3:0] < PP_PER_BARREL && (!sh_on_second || sh_twenty))
            shadow_words[WRD_PP_P] = pp;
          else
            shadow_words[WRD_PP_P] = '0;
        end
      end
      WRD_LOCK: shadow_words[WRD_LOCK][3:0] = '0;
      WRD_MEMQ: begin
        // thermometer of present quarters, codes past four show no quarters
        if (sh_model) begin
          for (int i = 0; i < 4; i++)
            shadow_words[WRD_MEMQ][8+i] = (sh_mem_size <= 4) && (i < sh_mem_size);
        end
      end
      WRD_MODEL: begin
        if (sh_model) begin
          shadow_words[WRD_MODEL][0] = 1'b1;
          shadow_words[WRD_MODEL][2:1] = 2'b00;
        end
      end
      WRD_CPU: begin
        shadow_words[WRD_CPU][0] = cpu;
        shadow_words[WRD_CPU][1] = 1'b0;
        shadow_words[WRD_CPU][3] = mon;
        shadow_words[WRD_CPU][4] = 1'b0;
        if (sh_model)
          shadow_words[WRD_CPU][10] = xa;
        shadow_words[WRD_CPU][11] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // applies one request to the shadow words and returns the reply it must produce
  function automatic logic [WORD_W-1:0] predict_reply(op_t opc, logic [DES_W-1:0] des,
                                                      logic [WORD_W-1:0] pp, logic cpu,
                                                      logic mon, logic xa);
    int unsigned w;
    int unsigned b;
    logic [WORD_W-1:0] result;
    w = des / WORD_W;
    b = des % WORD_W;
    result = '0;
    if (opc == OP_READ)
      refresh_word(des, pp, cpu, mon, xa);
    else if (opc == OP_TEST || opc == OP_TEST_CLEAR || opc == OP_TEST_SET)
      refresh_word(w, pp, cpu, mon, xa);
    case (opc)
      OP_READ: begin
        if (des < WORD_COUNT)
          result = shadow_words[des];
      end
      OP_TEST, OP_TEST_CLEAR, OP_TEST_SET: begin
        if (w < WORD_COUNT) begin
          result = {{(WORD_W-1){1'b0}}, shadow_words[w][b]};
          if (opc == OP_TEST_CLEAR)
            shadow_words[w][b] = 1'b0;
          else if (opc == OP_TEST_SET)
            shadow_words[w][b] = 1'b1;
        end
      end
      OP_CLEAR: begin
        // bits past the last word are dropped
        if (w < WORD_COUNT)
          shadow_words[w][b] = 1'b0;
      end
      OP_SET: begin
        if (w < WORD_COUNT)
          shadow_words[w][b] = 1'b1;
      end
      OP_CLEAR_ALL: begin
        foreach (shadow_words[i])
          shadow_words[i] = '0;
      end
      default: begin
        // error summary covers words 0-2 whole and the low nibble of word 3
        if ((|shadow_words[0]) || (|shadow_words[1]) || (|shadow_words[2]) ||
            (|shadow_words[3][3:0]))
          result = WORD_W'(1);
      end
    endcase
    return result;
  endfunction

  // ------------------------------------------------------------------------
  // reply side
  // ------------------------------------------------------------------------

  // stall pattern changes mode every so often; a hold-off request overrides it
  initial begin : reply_sink
    int mode;
    int mode_left;
    int hold_left;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_served != holdoff_requests) begin
        holdoff_served = holdoff_requests;
        hold_left = HOLDOFF_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;                             // no stalls at all
          1: out_stall <= ($urandom_range(0, 3) == 0);      // light
          2: out_stall <= ($urandom_range(0, 3) != 0);      // heavy
          default: out_stall <= (mode_left % 3 == 0);       // periodic
        endcase
      end
    end
  end

  // every reply transfer is matched against the oldest owed reply
  always @(posedge clk) begin : reply_check
    pending_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        failure_count++;
        if (failure_count <= MAX_REPORTED)
          $display("unexpected reply %h at cycle %0d", reply, cycle_count);
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (reply !== want.value) begin
          failure_count++;
          if (failure_count <= MAX_REPORTED)
            $display("reply mismatch: %s designator %0d expected %h got %h",
                     want.opc.name(), want.des, want.value, reply);
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // request side
  // ------------------------------------------------------------------------

  // holds one request until the block takes it, then books its reply
  task automatic send_request(op_t opc, logic [DES_W-1:0] des, logic [WORD_W-1:0] pp,
                              logic cpu, logic mon, logic xa);
    pending_reply_t entry;
    in_valid         <= 1'b1;
    op               <= opc;
    designator       <= des;
    selected_pp_p    <= pp;
    cpu_stopped      <= cpu;
    monitor_mode     <= mon;
    expanded_address <= xa;
    do @(posedge clk); while (in_stall);
    entry.opc   = opc;
    entry.des   = des;
    entry.value = predict_reply(opc, des, pp, cpu, mon, xa);
    pending_replies.push_back(entry);
    requests_sent++;
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // sender stops until every owed reply is in, then lets the pipeline settle
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all four registers back to back; upper data bits of one-bit
  // registers are junk on purpose, only bit 0 counts
  task automatic apply_setting(logic sec, logic tw, logic mdl, logic [CFG_DATA_W-1:0] mem);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ON_SECOND;
    cfg_data  <= {2'($urandom_range(0, 3)), sec};
    @(posedge clk);
    cfg_index <= CFG_TWENTY;
    cfg_data  <= {2'($urandom_range(0, 3)), tw};
    @(posedge clk);
    cfg_index <= CFG_MODEL;
    cfg_data  <= {2'($urandom_range(0, 3)), mdl};
    @(posedge clk);
    cfg_index <= CFG_MEM_SIZE;
    cfg_data  <= mem;
    @(posedge clk);
    cfg_write <= 1'b0;
    sh_on_second = sec;
    sh_twenty    = tw;
    sh_model     = mdl;
    sh_mem_size  = mem;
    settings_used++;
  endtask

  function automatic op_t pick_op();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return OP_READ;
    if (roll < 35) return OP_TEST;
    if (roll < 47) return OP_CLEAR;
    if (roll < 59) return OP_TEST_CLEAR;
    if (roll < 74) return OP_SET;
    if (roll < 86) return OP_TEST_SET;
    if (roll < 89) return OP_CLEAR_ALL;
    return OP_TEST_ERR;
  endfunction

  // mostly live words, with extra weight on the refreshed and control words
  function automatic logic [DES_W-1:0] pick_designator(op_t opc);
    int unsigned roll;
    int          hot;
    roll = $urandom_range(0, 99);
    if (opc == OP_READ) begin
      if (roll < 75) return DES_W'($urandom_range(0, WORD_COUNT + 4));
      return DES_W'($urandom_range(0, 255));
    end
    if (roll < 70) return DES_W'($urandom_range(0, WORD_COUNT * WORD_W - 1));
    if (roll < 88) begin
      case ($urandom_range(0, 3))
        0: hot = WRD_LOCK;
        1: hot = WRD_PP_SEL;
        2: hot = WRD_CPU;
        default: hot = WRD_PP_P;
      endcase
      return flat_bit(hot, $urandom_range(0, WORD_W - 1));
    end
    return DES_W'($urandom_range(0, 255));
  endfunction

  task automatic send_random_request();
    op_t               opc;
    logic [WORD_W-1:0] pp;
    opc = pick_op();
    case ($urandom_range(0, 9))
      0: pp = '0;
      1: pp = '1;
      default: pp = WORD_W'($urandom_range(0, 4095));
    endcase
    send_request(opc, pick_designator(opc), pp, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // bursts of random length with random gaps, now and then a long unbroken run
  // or a full stop until the block has answered everything
  task automatic run_random_traffic(int count);
    int burst_left;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        case ($urandom_range(0, 9))
          0: burst_left = $urandom_range(40, 80);
          1: burst_left = 1;
          default: burst_left = $urandom_range(2, 20);
        endcase
        if ($urandom_range(0, 39) == 0)
          drain_replies();
        else if ($urandom_range(0, 2) != 0)
          idle_for($urandom_range(1, 8));
      end
      send_random_request();
      burst_left--;
    end
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // reset state, each op, the refreshed words, lock, selector range, error summary
  task automatic test_directed();
    apply_setting(1'b0, 1'b0, 1'b1, 3'd4);
    send_request(OP_READ, '0, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_TEST_ERR, '1, '1, 1'b0, 1'b0, 1'b0);
    send_request(OP_SET, flat_bit(0, 0), '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_TEST_ERR, '0, '0, 1'b0, 1'b0, 1'b0);
    // stale top bit of the cpu word is cleared by the refresh before the test
    send_request(OP_TEST_SET, flat_bit(WRD_CPU, 11), '0, 1'b1, 1'b0, 1'b0);
    send_request(OP_READ, DES_W'(WRD_CPU), '0, 1'b1, 1'b1, 1'b1);
    send_request(OP_READ, DES_W'(WRD_MEMQ), '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_READ, DES_W'(WRD_MODEL), '0, 1'b0, 1'b0, 1'b0);
    // selector past the last pp of the barrel forces word 5 to zero
    send_request(OP_SET, flat_bit(WRD_PP_SEL, 2), '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_SET, flat_bit(WRD_PP_SEL, 3), '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_READ, DES_W'(WRD_PP_P), '1, 1'b0, 1'b0, 1'b0);
    send_request(OP_CLEAR, flat_bit(WRD_PP_SEL, 3), '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_READ, DES_W'(WRD_PP_P), 12'habc, 1'b0, 1'b0, 1'b0);
    // locked pp: word 5 keeps its value
    send_request(OP_SET, flat_bit(WRD_LOCK, 11), '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_READ, DES_W'(WRD_PP_P), 12'h123, 1'b0, 1'b0, 1'b0);
    send_request(OP_SET, flat_bit(WRD_LOCK, 0), '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_READ, DES_W'(WRD_LOCK), '0, 1'b0, 1'b0, 1'b0);
    // out-of-range bits and words
    send_request(OP_TEST, '1, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_SET, flat_bit(WORD_COUNT, 0), '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_READ, DES_W'(WORD_COUNT), '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_READ, '1, '1, 1'b1, 1'b1, 1'b1);
    send_request(OP_TEST_CLEAR, flat_bit(0, 0), '0, 1'b0, 1'b0, 1'b0);
    // only the low nibble of word 3 counts as an error
    send_request(OP_SET, flat_bit(3, 4), '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_TEST_ERR, '0, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_SET, flat_bit(3, 3), '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_TEST_ERR, '0, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_CLEAR_ALL, '0, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_READ, DES_W'(WRD_CPU), '0, 1'b0, 1'b0, 1'b0);
    drain_replies();
  endtask

  // random traffic under a spread of settings, memory codes 0..7 among them
  task automatic test_random_settings();
    // {on_second, twenty, model, memory size code}
    logic [5:0] plan [8] = '{6'b000_000, 6'b111_100, 6'b101_011, 6'b011_111,
                             6'b001_001, 6'b100_010, 6'b001_101, 6'b111_110};
    foreach (plan[s]) begin
      apply_setting(plan[s][5], plan[s][4], plan[s][3], plan[s][2:0]);
      run_random_traffic(RANDOM_PER_SETTING);
      drain_replies();
    end
  endtask

  // reply side holds off for a long stretch while requests keep coming,
  // so the block backs up into its request side
  task automatic test_backpressure();
    apply_setting(1'b0, 1'b1, 1'b1, 3'd2);
    holdoff_requests++;
    for (int i = 0; i < FLOOD_ITEMS; i++)
      send_random_request();
    drain_replies();
  endtask

  initial begin
    rst              <= 1'b1;
    in_valid         <= 1'b0;
    op               <= OP_READ;
    designator       <= '0;
    selected_pp_p    <= '0;
    cpu_stopped      <= 1'b0;
    monitor_mode     <= 1'b0;
    expanded_address <= 1'b0;
    cfg_write        <= 1'b0;
    cfg_index        <= CFG_ON_SECOND;
    cfg_data         <= '0;
    foreach (shadow_words[i])
      shadow_words[i] = '0;
    sh_on_second = 1'b0;
    sh_twenty    = 1'b0;
    sh_model     = 1'b0;
    sh_mem_size  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_settings();
    test_backpressure();
    drain_replies();

    if (pending_replies.size() != 0) begin
      failure_count += pending_replies.size();
      $display("%0d replies never arrived", pending_replies.size());
    end
    if (failure_count > MAX_REPORTED)
      $display("%0d failures in total", failure_count);
    $display("covered %0d requests over %0d register settings, %0d replies compared",
             requests_sent, settings_used, replies_checked);
    if (failure_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
